// ----- hdl/flux_stream_index_period_unit_assert.svh -----
// Assertion macros shared by the flux stream index period modules.
`ifndef FLUX_STREAM_INDEX_PERIOD_UNIT_ASSERT_SVH
`define FLUX_STREAM_INDEX_PERIOD_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FSIPU_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsipu: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FSIPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsipu: next-cycle check failed");

`endif

// ----- hdl/fsipu_pkg.sv -----
// Package: shared types, codes and constants of the flux stream index period unit.
package fsipu_pkg;

  localparam int unsigned VAL_W        = 28;
  localparam int unsigned TICK_W       = 32;
  localparam int unsigned CLK_NS_W     = 10;
  localparam int unsigned NS_W         = 42;
  localparam int unsigned FIFO_DEPTH_D = 4;

  // Command codes passed from the parser to the executor.
  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_INDEX   = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;
  localparam logic [1:0] CMD_END_ERR = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_INDEX   = 2'd1;
  localparam logic [1:0] ST_BAD_OPCODE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_CLOCK_NS = 2'd0;
  localparam logic [1:0] REG_INDEX_OP = 2'd1;
  localparam logic [1:0] REG_SPACE_OP = 2'd2;

  // Stream byte codes.
  localparam logic [7:0] BYTE_END    = 8'd0;
  localparam logic [7:0] BYTE_EXT_LO = 8'd250;
  localparam logic [7:0] BYTE_ESCAPE = 8'd255;

  typedef struct packed {
    logic [1:0]       code;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

// ----- hdl/fsipu_front.sv -----
// Byte parser: classifies stream bytes and issues commands to the executor.
`include "flux_stream_index_period_unit_assert.svh"
module fsipu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic                byte_stall,
  input  logic [7:0]          stream_byte,
  input  logic [7:0]          index_op,
  input  logic [7:0]          space_op,
  output logic                cmd_push,
  output fsipu_pkg::cmd_t     cmd
);

  localparam logic [2:0] PH_NORMAL = 3'd0;
  localparam logic [2:0] PH_EXT    = 3'd1;
  localparam logic [2:0] PH_OPCODE = 3'd2;
  localparam logic [2:0] PH_PACKED = 3'd3;
  localparam logic [2:0] PH_DRAIN  = 3'd4;

  logic [2:0]                   phase_r, phase_nxt;
  logic [2:0]                   ext_hi_r, ext_hi_nxt;
  logic [fsipu_pkg::VAL_W-1:0]  pv_r, pv_nxt, pv_merged;
  logic [1:0]                   cnt_r, cnt_nxt;
  logic                         is_idx_r, is_idx_nxt;
  logic                         acc;
  logic [10:0]                  ext_delta;

  assign acc = byte_valid && !byte_stall;

  // 249 + hi*255 + b, with hi*255 as (hi << 8) - hi
  assign ext_delta = 11'd249 + ({ext_hi_r, 8'd0} - {8'd0, ext_hi_r}) + {3'd0, stream_byte};

  always_comb begin
    pv_merged = pv_r;
    case (cnt_r)
      2'd0:    pv_merged[6:0]   = pv_r[6:0]   | stream_byte[7:1];
      2'd1:    pv_merged[13:7]  = pv_r[13:7]  | stream_byte[7:1];
      2'd2:    pv_merged[20:14] = pv_r[20:14] | stream_byte[7:1];
      default: pv_merged[27:21] = pv_r[27:21] | stream_byte[7:1];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    ext_hi_nxt = ext_hi_r;
    pv_nxt     = pv_r;
    cnt_nxt    = cnt_r;
    is_idx_nxt = is_idx_r;
    cmd_push   = 1'b0;
    cmd.code   = fsipu_pkg::CMD_ADD;
    cmd.value  = {{(fsipu_pkg::VAL_W-8){1'b0}}, stream_byte};
    if (acc) begin
      unique case (phase_r)
        PH_NORMAL: begin
          if (stream_byte == fsipu_pkg::BYTE_END) begin
            cmd_push = 1'b1;
            cmd.code = fsipu_pkg::CMD_END;
          end else if (stream_byte == fsipu_pkg::BYTE_ESCAPE) begin
            phase_nxt = PH_OPCODE;
          end else if (stream_byte >= fsipu_pkg::BYTE_EXT_LO) begin
            ext_hi_nxt = 3'(stream_byte - fsipu_pkg::BYTE_EXT_LO);
            phase_nxt  = PH_EXT;
          end else begin
            cmd_push = 1'b1;
          end
        end
        PH_EXT: begin
          cmd_push   = 1'b1;
          cmd.value  = {{(fsipu_pkg::VAL_W-11){1'b0}}, ext_delta};
          ext_hi_nxt = 3'd0;
          phase_nxt  = PH_NORMAL;
        end
        PH_OPCODE: begin
          if (stream_byte == index_op || stream_byte == space_op) begin
            is_idx_nxt = (stream_byte == index_op);
            pv_nxt     = '0;
            cnt_nxt    = 2'd0;
            phase_nxt  = PH_PACKED;
          end else begin
            phase_nxt = PH_DRAIN;
          end
        end
        PH_PACKED: begin
          if (cnt_r == 2'd3) begin
            cmd_push   = 1'b1;
            cmd.code   = is_idx_r ? fsipu_pkg::CMD_INDEX : fsipu_pkg::CMD_ADD;
            cmd.value  = pv_merged;
            pv_nxt     = '0;
            cnt_nxt    = 2'd0;
            is_idx_nxt = 1'b0;
            phase_nxt  = PH_NORMAL;
          end else begin
            pv_nxt  = pv_merged;
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        PH_DRAIN: begin
          if (stream_byte == fsipu_pkg::BYTE_END) begin
            cmd_push  = 1'b1;
            cmd.code  = fsipu_pkg::CMD_END_ERR;
            phase_nxt = PH_NORMAL;
          end
        end
        default: phase_nxt = PH_NORMAL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_NORMAL;
      ext_hi_r <= 3'd0;
      pv_r     <= '0;
      cnt_r    <= 2'd0;
      is_idx_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      ext_hi_r <= ext_hi_nxt;
      pv_r     <= pv_nxt;
      cnt_r    <= cnt_nxt;
      is_idx_r <= is_idx_nxt;
    end
  end

  // An extended byte always returns the parser to the normal phase.
  `FSIPU_ASSERT_NEXT(a_ext_returns, acc && phase_r == PH_EXT, phase_r == PH_NORMAL)

endmodule

// ----- hdl/fsipu_fifo.sv -----
// Command queue between the byte parser and the executor.
`include "flux_stream_index_period_unit_assert.svh"
module fsipu_fifo #(
  parameter int unsigned DEPTH = fsipu_pkg::FIFO_DEPTH_D
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fsipu_pkg::cmd_t wr_data,
  input  logic            pop,
  output fsipu_pkg::cmd_t rd_data,
  output logic            empty,
  output logic            full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  fsipu_pkg::cmd_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_FULL);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  `FSIPU_ASSERT_IMPLY(a_no_overflow, push, !full)
  `FSIPU_ASSERT_IMPLY(a_no_underflow, pop, !empty)

endmodule

// ----- hdl/fsipu_back.sv -----
// Executor: tick count, index times and the registered result pipeline.
`include "flux_stream_index_period_unit_assert.svh"
module fsipu_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fsipu_pkg::cmd_t                   cmd,
  input  logic                              cmd_empty,
  output logic                              cmd_pop,
  input  logic [fsipu_pkg::CLK_NS_W-1:0]    clk_ns,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fsipu_pkg::TICK_W-1:0]      out_period_ticks,
  output logic [fsipu_pkg::NS_W-1:0]        out_period_ns,
  output logic [1:0]                        out_status
);

  logic [fsipu_pkg::TICK_W-1:0] tick_r, first_r, second_r;
  logic                         first_seen_r, second_seen_r;
  logic                         res_valid_r;
  logic [fsipu_pkg::TICK_W-1:0] res_ticks_r;
  logic [1:0]                   res_status_r;
  logic                         out_valid_r;
  logic [fsipu_pkg::TICK_W-1:0] out_ticks_r;
  logic [fsipu_pkg::NS_W-1:0]   out_ns_r;
  logic [1:0]                   out_status_r;

  logic                         is_end, out_load, res_ready, res_load;
  logic [fsipu_pkg::TICK_W-1:0] val_ext, idx_time;
  logic [1:0]                   end_status;

  assign is_end    = (cmd.code == fsipu_pkg::CMD_END) || (cmd.code == fsipu_pkg::CMD_END_ERR);
  assign out_load  = !out_valid_r || !out_stall;
  assign res_ready = !res_valid_r || out_load;
  assign cmd_pop   = !cmd_empty && (!is_end || res_ready);
  assign res_load  = cmd_pop && is_end;
  assign val_ext   = {{(fsipu_pkg::TICK_W-fsipu_pkg::VAL_W){1'b0}}, cmd.value};
  assign idx_time  = tick_r + val_ext;

  always_comb begin
    if (cmd.code == fsipu_pkg::CMD_END_ERR) begin
      end_status = fsipu_pkg::ST_BAD_OPCODE;
    end else if (!second_seen_r) begin
      end_status = fsipu_pkg::ST_NO_INDEX;
    end else begin
      end_status = fsipu_pkg::ST_OK;
    end
  end

  // Stream state: advance on each popped command, clear at end of stream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r        <= '0;
      first_r       <= '0;
      second_r      <= '0;
      first_seen_r  <= 1'b0;
      second_seen_r <= 1'b0;
    end else if (cmd_pop) begin
      case (cmd.code)
        fsipu_pkg::CMD_ADD: tick_r <= idx_time;
        fsipu_pkg::CMD_INDEX: begin
          if (!first_seen_r) begin
            first_r      <= idx_time;
            first_seen_r <= 1'b1;
          end else if (!second_seen_r) begin
            second_r      <= idx_time;
            second_seen_r <= 1'b1;
          end
        end
        default: begin
          tick_r        <= '0;
          first_r       <= '0;
          second_r      <= '0;
          first_seen_r  <= 1'b0;
          second_seen_r <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (out_load) begin
        res_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= res_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status_r <= end_status;
      res_ticks_r  <= (end_status == fsipu_pkg::ST_OK) ? (second_r - first_r) : '0;
    end
    if (out_load && res_valid_r) begin
      out_ticks_r  <= res_ticks_r;
      out_status_r <= res_status_r;
      out_ns_r     <= fsipu_pkg::NS_W'(res_ticks_r) * fsipu_pkg::NS_W'(clk_ns);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_period_ticks = out_ticks_r;
  assign out_period_ns    = out_ns_r;
  assign out_status       = out_status_r;

  `FSIPU_ASSERT_IMPLY(a_fail_zero, out_valid_r && out_status_r != fsipu_pkg::ST_OK, out_ticks_r == '0 && out_ns_r == '0)
  `FSIPU_ASSERT_NEXT(a_end_clears, res_load, tick_r == '0 && !first_seen_r && !second_seen_r)

endmodule

// ----- hdl/flux_stream_index_period_unit.sv -----
// Top level of the flux stream index period unit: register port, parser, queue, executor.
//
// Decodes a floppy flux byte stream and reports the time between the first two index
// pulses. One byte is taken every cycle while in_stall is low; in_stall rises only when
// the command queue between parser and executor is full, which in steady flow it never
// is, since the executor retires one command per cycle. The executor stops only at a
// terminator while its two result registers are both held by out_stall. With the queue
// otherwise empty and out_stall low, the terminating byte is written to the queue, then
// loads the end-of-stream register, then the period_ticks times clock_ns_per_tick
// product register, which drives out_valid. Status 1 means fewer than two index pulses,
// status 2 an unknown opcode after an escape byte, and both give zero period fields.
// Configuration writes go through the APB-style port, registers at byte addresses 0, 4
// and 8; write them only while no stream is in flight.
module flux_stream_index_period_unit #(
  parameter int unsigned FIFO_DEPTH = fsipu_pkg::FIFO_DEPTH_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte transaction in
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_stream_byte,
  // result transaction out
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fsipu_pkg::TICK_W-1:0]   out_period_ticks,
  output logic [fsipu_pkg::NS_W-1:0]     out_period_ns,
  output logic [1:0]                     out_status,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [3:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  logic [fsipu_pkg::CLK_NS_W-1:0] clk_ns_r;
  logic [7:0]                     index_op_r, space_op_r;
  logic                           cfg_wr;
  logic [1:0]                     cfg_idx;

  logic            push, pop, q_empty, q_full;
  fsipu_pkg::cmd_t push_cmd, pop_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Write the addressed register in the access phase; drop writes past the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_ns_r   <= 10'd13;
      index_op_r <= 8'd1;
      space_op_r <= 8'd2;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fsipu_pkg::REG_CLOCK_NS: clk_ns_r   <= cfg_pwdata[fsipu_pkg::CLK_NS_W-1:0];
        fsipu_pkg::REG_INDEX_OP: index_op_r <= cfg_pwdata[7:0];
        fsipu_pkg::REG_SPACE_OP: space_op_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fsipu_pkg::REG_CLOCK_NS: cfg_prdata = {{(32-fsipu_pkg::CLK_NS_W){1'b0}}, clk_ns_r};
      fsipu_pkg::REG_INDEX_OP: cfg_prdata = {24'd0, index_op_r};
      fsipu_pkg::REG_SPACE_OP: cfg_prdata = {24'd0, space_op_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // Hold off the byte source only when the queue has no room.
  assign in_stall = q_full;

  fsipu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_valid),
    .byte_stall  (in_stall),
    .stream_byte (in_stream_byte),
    .index_op    (index_op_r),
    .space_op    (space_op_r),
    .cmd_push    (push),
    .cmd         (push_cmd)
  );

  fsipu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_cmd),
    .pop     (pop),
    .rd_data (pop_cmd),
    .empty   (q_empty),
    .full    (q_full)
  );

  fsipu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (pop_cmd),
    .cmd_empty        (q_empty),
    .cmd_pop          (pop),
    .clk_ns           (clk_ns_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_period_ticks (out_period_ticks),
    .out_period_ns    (out_period_ns),
    .out_status       (out_status)
  );

endmodule

// ----- sim/testbench.sv -----
// Testbench for the flux stream index period unit: byte streams in, period results checked.
module testbench;

  // Cycles to let pass after the last expected result: three stages plus margin.
  localparam int unsigned SETTLE_CYCLES    = 8;
  // Receiver hold-off used to back the block up into in_stall.
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned PRESSURE_STREAMS = 40;
  // Random bytes per configuration phase; seven phases make up the random part.
  localparam int unsigned ITEMS_PER_PHASE  = 40;
  localparam int unsigned LAST_PHASE       = 7;
  localparam int unsigned LIMIT_CYCLES     = 400000;
  // Weight of the high part of an extended delta.
  localparam logic [31:0] EXT_STEP         = 32'd255;
  // Opcode that neither reset register value matches.
  localparam logic [7:0]  UNUSED_OPCODE    = 8'd9;

  typedef enum logic [2:0] {
    SCAN_NORMAL,
    SCAN_EXT,
    SCAN_OPCODE,
    SCAN_PACKED,
    SCAN_DRAIN
  } scan_phase_t;

  typedef struct packed {
    logic [fsipu_pkg::TICK_W-1:0] ticks;
    logic [fsipu_pkg::NS_W-1:0]   ns;
    logic [1:0]                   status;
  } period_result_t;

  // Tracks the stream as the block should see it and holds the periods still to come.
  class flux_period_board;
    logic [fsipu_pkg::CLK_NS_W-1:0] ns_per_tick;
    logic [7:0]                     index_op;
    logic [7:0]                     space_op;
    scan_phase_t                    phase;
    logic [fsipu_pkg::TICK_W-1:0]   tick_total;
    logic [fsipu_pkg::VAL_W-1:0]    packed_value;
    logic [1:0]                     packed_count;
    bit                             pending_index;
    logic [2:0]                     ext_high;
    logic [fsipu_pkg::TICK_W-1:0]   first_time;
    logic [fsipu_pkg::TICK_W-1:0]   second_time;
    bit                             first_seen;
    bit                             second_seen;
    bit                             bad_opcode;
    int unsigned                    bytes_in_stream;
    int unsigned                    failures;
    period_result_t                 expected_periods[$];

    function new();
      ns_per_tick = 10'd13;
      index_op    = 8'd1;
      space_op    = 8'd2;
      failures    = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      phase           = SCAN_NORMAL;
      tick_total      = '0;
      packed_value    = '0;
      packed_count    = '0;
      pending_index   = 1'b0;
      ext_high        = '0;
      first_time      = '0;
      second_time     = '0;
      first_seen      = 1'b0;
      second_seen     = 1'b0;
      bad_opcode      = 1'b0;
      bytes_in_stream = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        fsipu_pkg::REG_CLOCK_NS: ns_per_tick = value[fsipu_pkg::CLK_NS_W-1:0];
        fsipu_pkg::REG_INDEX_OP: index_op = value[7:0];
        fsipu_pkg::REG_SPACE_OP: space_op = value[7:0];
        default: ;
      endcase
    endfunction

    // Terminator: work out the period and return the stream state to reset.
    function void close_stream();
      period_result_t r;
      r.ticks = '0;
      r.ns    = '0;
      if (bad_opcode) begin
        r.status = fsipu_pkg::ST_BAD_OPCODE;
      end else if (!second_seen) begin
        r.status = fsipu_pkg::ST_NO_INDEX;
      end else begin
        r.status = fsipu_pkg::ST_OK;
        r.ticks  = second_time - first_time;
        r.ns     = fsipu_pkg::NS_W'(r.ticks) * fsipu_pkg::NS_W'(ns_per_tick);
      end
      expected_periods.push_back(r);
      clear_stream();
    endfunction

    function void note_byte(logic [7:0] b);
      logic [fsipu_pkg::VAL_W-1:0]  merged;
      logic [fsipu_pkg::TICK_W-1:0] stamp;
      bytes_in_stream++;
      case (phase)
        SCAN_NORMAL: begin
          if (b == fsipu_pkg::BYTE_END) begin
            close_stream();
          end else if (b == fsipu_pkg::BYTE_ESCAPE) begin
            phase = SCAN_OPCODE;
          end else if (b >= fsipu_pkg::BYTE_EXT_LO) begin
            ext_high = 3'(b - fsipu_pkg::BYTE_EXT_LO);
            phase    = SCAN_EXT;
          end else begin
            tick_total += fsipu_pkg::TICK_W'(b);
          end
        end
        SCAN_EXT: begin
          // a zero here is data
          tick_total += fsipu_pkg::TICK_W'(fsipu_pkg::BYTE_EXT_LO)
                        + fsipu_pkg::TICK_W'(ext_high) * EXT_STEP
                        + fsipu_pkg::TICK_W'(b) - 32'd1;
          ext_high = '0;
          phase    = SCAN_NORMAL;
        end
        SCAN_OPCODE: begin
          // equal opcode registers resolve to an index
          if (b == index_op || b == space_op) begin
            pending_index = (b == index_op);
            packed_value  = '0;
            packed_count  = '0;
            phase         = SCAN_PACKED;
          end else begin
            bad_opcode = 1'b1;
            phase      = SCAN_DRAIN;
          end
        end
        SCAN_PACKED: begin
          merged = packed_value | (fsipu_pkg::VAL_W'(b[7:1]) << (7 * packed_count));
          if (packed_count == 2'd3) begin
            if (pending_index) begin
              stamp = fsipu_pkg::TICK_W'(merged) + tick_total;
              // third and later index pulses fall through untouched
              if (!first_seen) begin
                first_time = stamp;
                first_seen = 1'b1;
              end else if (!second_seen) begin
                second_time = stamp;
                second_seen = 1'b1;
              end
            end else begin
              tick_total += fsipu_pkg::TICK_W'(merged);
            end
            packed_value  = '0;
            packed_count  = '0;
            pending_index = 1'b0;
            phase         = SCAN_NORMAL;
          end else begin
            packed_value = merged;
            packed_count++;
          end
        end
        default: begin
          if (b == fsipu_pkg::BYTE_END) close_stream();
        end
      endcase
    endfunction

    function void check_period(logic [fsipu_pkg::TICK_W-1:0] ticks,
                               logic [fsipu_pkg::NS_W-1:0] ns,
                               logic [1:0] status);
      period_result_t want;
      if (expected_periods.size() == 0) begin
        failures++;
        $display("%0t: result with nothing expected: ticks %0h ns %0h status %0d",
                 $time, ticks, ns, status);
      end else begin
        want = expected_periods.pop_front();
        if (ticks !== want.ticks) begin
          failures++;
          $display("%0t: period_ticks expected %0h actual %0h", $time, want.ticks, ticks);
        end
        if (ns !== want.ns) begin
          failures++;
          $display("%0t: period_ns expected %0h actual %0h", $time, want.ns, ns);
        end
        if (status !== want.status) begin
          failures++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
      end
    endfunction
  endclass

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_stream_byte = 8'd0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic [fsipu_pkg::TICK_W-1:0]   out_period_ticks;
  logic [fsipu_pkg::NS_W-1:0]     out_period_ns;
  logic [1:0]                     out_status;
  logic                           cfg_psel       = 1'b0;
  logic                           cfg_penable    = 1'b0;
  logic                           cfg_pwrite     = 1'b0;
  logic [3:0]                     cfg_paddr      = 4'd0;
  logic [31:0]                    cfg_pwdata     = 32'd0;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;

  flux_period_board    sb = new();
  logic [7:0]          stream_bytes[$];
  int unsigned         burst_left    = 0;
  bit                  hold_off_req  = 1'b0;

  flux_stream_index_period_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_period_ticks (out_period_ticks),
    .out_period_ns    (out_period_ns),
    .out_status       (out_status),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels at the edge; values read here are the ones the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_byte(in_stream_byte);
    if (rst_n && out_valid && !out_stall)
      sb.check_period(out_period_ticks, out_period_ns, out_status);
  end

  // Receiver: stall in modes of random length; on request hold off for a long stretch.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // Offer one byte and hold it until accepted; open a random gap before each burst.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_queued();
    while (stream_bytes.size() != 0) send_byte(stream_bytes.pop_front());
  endtask

  // Drop valid, wait out every expected period plus the pipeline, and close any
  // stream left open so that the block is idle afterwards.
  task automatic settle_phase();
    bit open_stream;
    open_stream = 1'b1;
    while (open_stream) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      do @(posedge clk); while (sb.expected_periods.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
      open_stream = (sb.bytes_in_stream != 0);
      if (open_stream) send_byte(fsipu_pkg::BYTE_END);
    end
  endtask

  // Setup phase, then access phase, then idle before the next transfer.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [9:0] ns_tick, input logic [7:0] idx_op,
                                input logic [7:0] spc_op);
    write_register(fsipu_pkg::REG_CLOCK_NS, 32'(ns_tick));
    write_register(fsipu_pkg::REG_INDEX_OP, 32'(idx_op));
    write_register(fsipu_pkg::REG_SPACE_OP, 32'(spc_op));
  endtask

  // Escape, opcode, then four bytes of seven value bits each; bit 0 is random filler.
  function void push_escape(logic [7:0] opcode, logic [fsipu_pkg::VAL_W-1:0] value);
    int k;
    stream_bytes.push_back(fsipu_pkg::BYTE_ESCAPE);
    stream_bytes.push_back(opcode);
    for (k = 0; k < 4; k++) stream_bytes.push_back({value[7*k +: 7], 1'($urandom)});
  endfunction

  // Mostly well-formed streams with two index pulses; some with fewer or more,
  // some ending in a bad opcode, and a share of raw noise.
  function void build_stream();
    int unsigned kind;
    int unsigned n_index;
    int unsigned i;
    logic [7:0]  op;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) stream_bytes.push_back(8'($urandom));
    end else begin
      case (kind)
        1, 2: n_index = $urandom_range(0, 1);
        3: n_index = $urandom_range(3, 4);
        default: n_index = 2;
      endcase
      for (i = 0; i <= n_index; i++) begin
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 2))
            0: stream_bytes.push_back(8'($urandom_range(1, 249)));
            1: begin
              stream_bytes.push_back(8'($urandom_range(250, 254)));
              stream_bytes.push_back(8'($urandom));
            end
            default: push_escape(sb.space_op,
                                 fsipu_pkg::VAL_W'($urandom >> $urandom_range(0, 31)));
          endcase
        end
        if (i < n_index)
          push_escape(sb.index_op, fsipu_pkg::VAL_W'($urandom >> $urandom_range(0, 31)));
      end
      if (kind == 1) begin
        do op = 8'($urandom); while (op == sb.index_op || op == sb.space_op);
        stream_bytes.push_back(fsipu_pkg::BYTE_ESCAPE);
        stream_bytes.push_back(op);
        repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom_range(1, 255)));
      end
    end
    stream_bytes.push_back(fsipu_pkg::BYTE_END);
  endfunction

  initial begin
    int unsigned phase;
    int unsigned phase_items;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed stream on reset registers: a space, a first index with bit 0 set,
    // extended deltas at both ends (zero as data), a full-scale second index.
    // Then an empty stream and a bad opcode dropped up to its terminator.
    stream_bytes = {fsipu_pkg::BYTE_ESCAPE, sb.space_op, 8'h02, 8'h00, 8'h00, 8'h00,
                    fsipu_pkg::BYTE_ESCAPE, sb.index_op, 8'hFE, 8'h00, 8'h00, 8'h01,
                    fsipu_pkg::BYTE_EXT_LO, 8'd0, fsipu_pkg::BYTE_EXT_LO + 8'd4, 8'd255,
                    8'd249,
                    fsipu_pkg::BYTE_ESCAPE, sb.index_op, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    fsipu_pkg::BYTE_END,
                    fsipu_pkg::BYTE_END,
                    fsipu_pkg::BYTE_ESCAPE, UNUSED_OPCODE, fsipu_pkg::BYTE_END};
    send_queued();
    settle_phase();

    for (phase = 1; phase <= LAST_PHASE; phase++) begin
      case (phase)
        1: write_settings(10'd1023, 8'd0, 8'd255);
        2: write_settings(10'd0, 8'd255, 8'd0);      // zero clock gives zero ns
        3: write_settings(10'd1, 8'd7, 8'd7);        // equal opcodes
        4: write_settings(10'd1000, 8'($urandom), 8'($urandom));
        default: write_settings(10'($urandom_range(1, 1000)), 8'($urandom), 8'($urandom));
      endcase
      if (phase == 4) begin
        // Hold the receiver off while short streams keep coming without gaps.
        hold_off_req = 1'b1;
        burst_left   = 100000;
        repeat (PRESSURE_STREAMS) begin
          if ($urandom_range(0, 1) == 1) stream_bytes.push_back(8'($urandom_range(1, 249)));
          stream_bytes.push_back(fsipu_pkg::BYTE_END);
        end
        send_queued();
        burst_left = 0;
      end
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        build_stream();
        phase_items += stream_bytes.size();
        send_queued();
      end
      settle_phase();
    end

    if (sb.failures == 0 && sb.expected_periods.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(8 * LIMIT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- flux_stream_index_period_unit.f -----
+incdir+hdl
hdl/fsipu_pkg.sv
hdl/fsipu_front.sv
hdl/fsipu_fifo.sv
hdl/fsipu_back.sv
hdl/flux_stream_index_period_unit.sv
sim/testbench.sv
